// ----- rtl/clcg_pkg.sv -----
// Shared constants and types for the combined congruential generator with shuffle table.
`default_nettype none

package clcg_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 8);
  localparam int QW          = IDX_W + 2;

  // Generator moduli, multipliers and folding constants (2^31 - modulus)
  localparam logic [30:0] MOD1    = 31'd2147483563;
  localparam logic [30:0] MOD2    = 31'd2147483399;
  localparam logic [15:0] MUL1    = 16'd40014;
  localparam logic [15:0] MUL2    = 16'd40692;
  localparam logic [7:0]  FOLD1   = 8'd85;
  localparam logic [7:0]  FOLD2   = 8'd249;
  localparam logic [30:0] TOP_DEV = 31'd2147483562;
  localparam logic [30:0] GEN2_RST = 31'd123456789;

  // Bucket width of the shuffle index and a reciprocal for dividing by it
  localparam longint BUCKET_L = 64'd1 + 64'd2147483562 / TABLE_DEPTH;
  localparam int     BKT_LOG  = $clog2(BUCKET_L);
  localparam int     KSH      = BKT_LOG + 8;
  localparam longint RECIP_L  = (64'd1 << KSH) / BUCKET_L;
  localparam logic [30:0] BUCKET = 31'(BUCKET_L);
  localparam logic [8:0]  RECIP  = 9'(RECIP_L);

  typedef enum logic [1:0] {
    OP_NEXT   = 2'd0,
    OP_RESEED = 2'd1,
    OP_LOAD   = 2'd2
  } op_t;

  // Request to the shared modular multiplier
  typedef struct packed {
    logic        go;
    logic        gen2;
    logic [30:0] x;
  } mm_req_t;

endpackage

`default_nettype wire

// ----- rtl/combined_lcg_shuffle_rng_top.sv -----
// Top level: sequencer, generator state and shuffle table of the combined generator.
//
// Usage:
//   Input channel (in_valid / in_stall, in_opcode, in_seed) takes one request;
//   each request yields exactly one deviate on the result channel
//   (out_valid / out_stall, out_deviate), in the range 1..2147483562.
//   Opcode 0 steps, opcode 1 reseeds (warm-up and table load, then a step),
//   opcode 2 loads the first generator and steps (reseeds on seed 0); opcode 3 steps.
//   The shared modular multiplier has two stages; both generator multiplies
//   share it, followed by one table read and one write.
//   A reseed runs TABLE_DEPTH+8 warm-up steps, and every warm-up
//   step waits on the previous multiplier result.
//   in_stall is high from acceptance until the result is registered, so one
//   request is in flight at a time; a new request is taken while a finished
//   result still waits on out_stall.
//   If the receiver stalls, the result holds and a finished step waits in its
//   write-back state until the output register frees.
//   Reset: first generator 1, second 123456789, table reads as zero, previous
//   deviate 0, no result pending.
`default_nettype none

module combined_lcg_shuffle_rng_top
  import clcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [30:0] in_seed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_deviate
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_RS_ISS  = 8'b0000_0010,
    ST_RS_WAIT = 8'b0000_0100,
    ST_RS_TAKE = 8'b0000_1000,
    ST_MUL1    = 8'b0001_0000,
    ST_MUL2    = 8'b0010_0000,
    ST_RD      = 8'b0100_0000,
    ST_WB      = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [30:0]       first_r, first_nxt;
  logic [30:0]       second_r, second_nxt;
  logic [30:0]       last_r, last_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [30:0]       out_dev_r, out_dev_nxt;

  mm_req_t           mm_req;
  logic [30:0]       mm_res;
  logic              bkt_go;
  logic [IDX_W-1:0]  idx;

  logic [30:0]       tbl_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_r;
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic [30:0]       tbl_wdata;
  logic              tbl_re;
  logic [30:0]       rd_data_r;
  logic              rd_ok_r;

  logic [30:0]       seed_c;
  logic [30:0]       seed_one;
  logic              reseed_go;
  logic [30:0]       entry;
  logic [31:0]       diff;
  logic [31:0]       y;
  logic              wb_go;

  clcg_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .res   (mm_res)
  );

  clcg_bucket u_bucket (
    .clk   (clk),
    .go    (bkt_go),
    .value (last_r),
    .idx   (idx)
  );

  assign seed_c    = (in_seed > TOP_DEV) ? TOP_DEV : in_seed;
  assign seed_one  = (seed_c == 31'd0) ? 31'd1 : seed_c;
  assign reseed_go = (in_opcode == OP_RESEED) ||
                     ((in_opcode == OP_LOAD) && (seed_c == 31'd0));

  // Deviate: selected entry minus second generator, wrapped into 1..TOP_DEV
  assign entry = rd_ok_r ? rd_data_r : 31'd0;
  assign diff  = {1'b0, entry} - {1'b0, mm_res};
  assign y     = ($signed(diff) < 32'sd1) ? (diff + {1'b0, TOP_DEV}) : diff;
  assign wb_go = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dev_nxt   = out_dev_r;
    mm_req        = '0;
    bkt_go        = 1'b0;
    tbl_we        = 1'b0;
    tbl_waddr     = idx;
    tbl_wdata     = first_r;
    tbl_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (reseed_go) begin
            first_nxt  = seed_one;
            second_nxt = seed_one;
            cnt_nxt    = CNT_W'(TABLE_DEPTH + 7);
            state_nxt  = ST_RS_ISS;
          end else begin
            if (in_opcode == OP_LOAD) begin
              first_nxt = seed_c;
            end
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_RS_ISS: begin
        mm_req.go   = 1'b1;
        mm_req.gen2 = 1'b0;
        mm_req.x    = first_r;
        state_nxt   = ST_RS_WAIT;
      end
      ST_RS_WAIT: begin
        state_nxt = ST_RS_TAKE;
      end
      ST_RS_TAKE: begin
        first_nxt = mm_res;
        // The last TABLE_DEPTH warm-up values fill the table top down
        if (cnt_r < CNT_W'(TABLE_DEPTH)) begin
          tbl_we    = 1'b1;
          tbl_waddr = cnt_r[IDX_W-1:0];
          tbl_wdata = mm_res;
        end
        if (cnt_r == '0) begin
          last_nxt  = mm_res;
          state_nxt = ST_MUL1;
        end else begin
          cnt_nxt     = cnt_r - CNT_W'(1);
          mm_req.go   = 1'b1;
          mm_req.gen2 = 1'b0;
          mm_req.x    = mm_res;
          state_nxt   = ST_RS_WAIT;
        end
      end
      ST_MUL1: begin
        mm_req.go   = 1'b1;
        mm_req.gen2 = 1'b0;
        mm_req.x    = first_r;
        bkt_go      = 1'b1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        mm_req.go   = 1'b1;
        mm_req.gen2 = 1'b1;
        mm_req.x    = second_r;
        state_nxt   = ST_RD;
      end
      ST_RD: begin
        first_nxt = mm_res;
        tbl_re    = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // Hold here while the previous result still waits
        if (wb_go) begin
          second_nxt    = mm_res;
          tbl_we        = 1'b1;
          tbl_waddr     = idx;
          tbl_wdata     = first_r;
          last_nxt      = y[30:0];
          out_valid_nxt = 1'b1;
          out_dev_nxt   = y[30:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 31'd1;
      second_r    <= GEN2_RST;
      last_r      <= 31'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dev_r <= out_dev_nxt;
  end

  // Shuffle table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      rd_data_r <= tbl_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[tbl_waddr] <= 1'b1;
      end
      if (tbl_re) begin
        rd_ok_r <= tbl_vld_r[idx];
      end
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_deviate = out_dev_r;

endmodule

`default_nettype wire

// ----- rtl/clcg_mulmod.sv -----
// Shared two-stage unit computing (multiplier * x) mod modulus for either generator.
`default_nettype none

module clcg_mulmod
  import clcg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mm_req_t req,
  output logic [30:0]  res
);

  logic [15:0] mul_sel;
  logic [46:0] prod;
  logic [46:0] prod_r;
  logic        gen2_r;
  logic        v1_r;
  logic [30:0] res_r;
  logic [7:0]  fold_c;
  logic [30:0] mod_c;
  logic [23:0] hc;
  logic [31:0] fold;
  logic [31:0] fixed;

  assign mul_sel = req.gen2 ? MUL2 : MUL1;
  assign prod    = {16'b0, req.x} * {31'b0, mul_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req.go;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= prod;
      gen2_r <= req.gen2;
    end
  end

  // Fold the high part back in: 2^31 == fold constant (mod m), then one subtract
  assign fold_c = gen2_r ? FOLD2 : FOLD1;
  assign mod_c  = gen2_r ? MOD2 : MOD1;
  assign hc     = prod_r[46:31] * {8'b0, fold_c};
  assign fold   = {1'b0, prod_r[30:0]} + {8'b0, hc};
  assign fixed  = (fold >= {1'b0, mod_c}) ? (fold - {1'b0, mod_c}) : fold;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      res_r <= fixed[30:0];
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/clcg_bucket.sv -----
// Shuffle table index: previous deviate divided by the bucket width, saturated.
`default_nettype none

module clcg_bucket
  import clcg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             go,
  input  wire logic [30:0]      value,
  output logic [IDX_W-1:0]      idx
);

  logic [39:0]         rprod;
  logic [39:0]         rshift;
  logic [QW-1:0]       q0_r;
  logic [30:0]         v_r;
  logic [QW+30:0]      qb;
  logic [QW+30:0]      rem;
  logic [QW-1:0]       q;
  logic [IDX_W-1:0]    idx_r;

  // Estimate is exact or one low
  assign rprod  = {9'b0, value} * {31'b0, RECIP};
  assign rshift = rprod >> KSH;

  always_ff @(posedge clk) begin
    if (go) begin
      q0_r <= rshift[QW-1:0];
      v_r  <= value;
    end
  end

  assign qb  = {31'b0, q0_r} * {{QW{1'b0}}, BUCKET};
  assign rem = {{QW{1'b0}}, v_r} - qb;
  assign q   = (rem >= {{QW{1'b0}}, BUCKET}) ? (q0_r + QW'(1)) : q0_r;

  always_ff @(posedge clk) begin
    if (q >= QW'(TABLE_DEPTH)) begin
      idx_r <= IDX_W'(TABLE_DEPTH - 1);
    end else begin
      idx_r <= q[IDX_W-1:0];
    end
  end

  assign idx = idx_r;

endmodule

`default_nettype wire

// ----- rtl/clcg_checker.sv -----
// Port-level checker for the combined generator top level, with its bind.
`default_nettype none

module clcg_checker
  import clcg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [30:0] out_deviate
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_deviate))
    else $error("stalled result changed or dropped");

  // Deviate stays in 1..TOP_DEV
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_deviate != 31'd0) && (out_deviate <= TOP_DEV))
    else $error("deviate out of range");

  // A request keeps the block busy through its multiply and read states
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("block ready too early after a request");

  // Reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the channels");

endmodule

bind combined_lcg_shuffle_rng_top clcg_checker u_clcg_checker (.*);

`default_nettype wire
